[hdl/cmi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmi_pkg
// Shared types, constants and arithmetic helpers of the camera motion
// integrator.
// ----------------------------------------------------------------------------
package cmi_pkg;

  localparam int unsigned DenW    = 24;
  localparam int unsigned NumAxes = 5;   // position x, y, z, rotation x, y
  localparam int unsigned AxisW   = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [AxisW-1:0] AxisPosX = 3'd0;
  localparam logic [AxisW-1:0] AxisPosY = 3'd1;
  localparam logic [AxisW-1:0] AxisPosZ = 3'd2;
  localparam logic [AxisW-1:0] AxisRotX = 3'd3;
  localparam logic [AxisW-1:0] AxisRotY = 3'd4;

  localparam logic [2:0] OpTick     = 3'd0;
  localparam logic [2:0] OpBoostPos = 3'd1;
  localparam logic [2:0] OpBoostRot = 3'd2;
  localparam logic [2:0] OpSetPos   = 3'd3;
  localparam logic [2:0] OpSetRot   = 3'd4;

  localparam logic [CfgIdxW-1:0] RegBoxEnabled = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBoxMinX    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBoxMaxX    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBoxMinY    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBoxMaxY    = 3'd4;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        step_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic               clear_motion;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [31:0] rotation_x;
    logic signed [31:0] rotation_y;
    logic               bounced_x;
    logic               bounced_y;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             simple;
    logic             mul;
    logic             add;
    logic             wb;
    logic             clamp;
    logic             out_load;
    logic [AxisW-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic step_zero;
    logic div_done;
  } status_t;

  // Saturates a 35-bit signed value to the 32-bit range.
  function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
    logic signed [31:0] r;
    if ((x[34:31] == 4'b0000) || (x[34:31] == 4'b1111)) begin
      r = x[31:0];
    end else if (x[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/cmi_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmi_div
// Damping divider: x * 65536 / den, truncated toward zero and saturated,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmi_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [31:0]             x_i,
  input  wire logic [cmi_pkg::DenW-1:0]       den_i,
  output logic                                done_o,
  output logic signed [31:0]                  result_o
);

  logic [cmi_pkg::DenW:0] rem_q, rem_d;
  logic [30:0]            shr_q, shr_d;
  logic [30:0]            quot_q, quot_d;
  logic [cmi_pkg::DenW-1:0] den_q, den_d;
  logic                   neg_q, neg_d;
  logic                   ovf_q, ovf_d;
  logic [4:0]             cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [31:0]            mag;
  logic [cmi_pkg::DenW+1:0] trial;

  assign mag   = x_i[31] ? (32'd0 - x_i) : x_i;
  assign trial = {rem_q, shr_q[30]} - {2'b00, den_q};

  always_comb begin
    rem_d  = rem_q;
    shr_d  = shr_q;
    quot_d = quot_q;
    den_d  = den_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // The quotient reaches 2^31 exactly when the magnitude reaches den * 2^15.
      neg_d  = x_i[31];
      ovf_d  = ({7'd0, mag} >= {den_i, 15'd0});
      rem_d  = {8'd0, mag[31:15]};
      shr_d  = {mag[14:0], 16'd0};
      quot_d = '0;
      den_d  = den_i;
      cnt_d  = 5'd31;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[cmi_pkg::DenW+1]) begin
        rem_d  = trial[cmi_pkg::DenW:0];
        quot_d = {quot_q[29:0], 1'b1};
      end else begin
        rem_d  = {rem_q[cmi_pkg::DenW-1:0], shr_q[30]};
        quot_d = {quot_q[29:0], 1'b0};
      end
      shr_d = {shr_q[29:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    shr_q  <= shr_d;
    quot_q <= quot_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    ovf_q  <= ovf_d;
  end

  always_comb begin
    if (ovf_q) begin
      result_o = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg_q) begin
      result_o = 32'sd0 - $signed({1'b0, quot_q});
    end else begin
      result_o = $signed({1'b0, quot_q});
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

[hdl/cmi_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmi_datapath
// Motion state, configuration registers, integration multipliers, damping
// dividers, box clamp and the result register.
// ----------------------------------------------------------------------------
module cmi_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cmi_pkg::in_item_t             in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [cmi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire cmi_pkg::cmd_t                 cmd_i,
  output cmi_pkg::status_t                   status_o,
  output cmi_pkg::out_item_t                 out_data_o
);

  logic               box_en_q;
  logic signed [31:0] min_x_q, max_x_q, min_y_q, max_y_q;

  logic signed [31:0] pos_q [cmi_pkg::NumAxes];
  logic signed [31:0] vel_q [cmi_pkg::NumAxes];
  logic signed [31:0] acc_q [cmi_pkg::NumAxes];

  cmi_pkg::in_item_t  item_q;
  logic [31:0]        dd_q;
  logic [cmi_pkg::DenW-1:0] den_a_q, den_v_q;
  logic signed [64:0] prod_add_q;
  logic signed [48:0] prod_vd_q, prod_ad_q;
  logic               bx_q, by_q;
  cmi_pkg::out_item_t out_q;

  logic signed [31:0] cur_p, cur_v, cur_a;
  logic signed [34:0] sum_p;
  logic signed [31:0] new_p, new_v;
  logic               div_a_done, div_v_done;
  logic signed [31:0] div_a_res, div_v_res;
  logic [cmi_pkg::DenW-1:0] in_d;

  assign cur_p = pos_q[cmd_i.axis];
  assign cur_v = vel_q[cmd_i.axis];
  assign cur_a = acc_q[cmd_i.axis];

  assign sum_p = {{3{cur_p[31]}}, cur_p}
               + {{3{prod_add_q[64]}}, prod_add_q[64:33]}
               + {{2{prod_vd_q[48]}}, prod_vd_q[48:16]};
  assign new_p = cmi_pkg::sat35(sum_p);
  assign new_v = cmi_pkg::sat35({{3{cur_v[31]}}, cur_v}
                                + {{2{prod_ad_q[48]}}, prod_ad_q[48:16]});

  assign in_d = {8'd0, in_data_i.step_time};

  cmi_div u_div_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.add),
    .x_i      (cur_a),
    .den_i    (den_a_q),
    .done_o   (div_a_done),
    .result_o (div_a_res)
  );

  cmi_div u_div_v (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.add),
    .x_i      (new_v),
    .den_i    (den_v_q),
    .done_o   (div_v_done),
    .result_o (div_v_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_en_q <= 1'b0;
      min_x_q  <= '0;
      max_x_q  <= '0;
      min_y_q  <= '0;
      max_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmi_pkg::RegBoxEnabled: box_en_q <= cfg_data_i[0];
        cmi_pkg::RegBoxMinX:    min_x_q  <= cfg_data_i;
        cmi_pkg::RegBoxMaxX:    max_x_q  <= cfg_data_i;
        cmi_pkg::RegBoxMinY:    min_y_q  <= cfg_data_i;
        cmi_pkg::RegBoxMaxY:    max_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Motion state and bounce flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cmi_pkg::NumAxes; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
      bx_q <= 1'b0;
      by_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        bx_q <= 1'b0;
        by_q <= 1'b0;
      end
      if (cmd_i.simple) begin
        case (item_q.operation)
          cmi_pkg::OpBoostPos: begin
            acc_q[cmi_pkg::AxisPosX] <= cmi_pkg::sat35(35'(acc_q[cmi_pkg::AxisPosX])
                                                       + 35'(item_q.value_x));
            acc_q[cmi_pkg::AxisPosY] <= cmi_pkg::sat35(35'(acc_q[cmi_pkg::AxisPosY])
                                                       + 35'(item_q.value_y));
            acc_q[cmi_pkg::AxisPosZ] <= cmi_pkg::sat35(35'(acc_q[cmi_pkg::AxisPosZ])
                                                       + 35'(item_q.value_z));
          end
          cmi_pkg::OpBoostRot: begin
            acc_q[cmi_pkg::AxisRotX] <= cmi_pkg::sat35(35'(acc_q[cmi_pkg::AxisRotX])
                                                       + 35'(item_q.value_x));
            acc_q[cmi_pkg::AxisRotY] <= cmi_pkg::sat35(35'(acc_q[cmi_pkg::AxisRotY])
                                                       + 35'(item_q.value_y));
          end
          cmi_pkg::OpSetPos: begin
            pos_q[cmi_pkg::AxisPosZ] <= item_q.value_z;
            if (box_en_q && (item_q.value_x < min_x_q)) begin
              pos_q[cmi_pkg::AxisPosX] <= min_x_q;
              bx_q <= 1'b1;
            end else if (box_en_q && (item_q.value_x > max_x_q)) begin
              pos_q[cmi_pkg::AxisPosX] <= max_x_q;
              bx_q <= 1'b1;
            end else begin
              pos_q[cmi_pkg::AxisPosX] <= item_q.value_x;
            end
            if (box_en_q && (item_q.value_y < min_y_q)) begin
              pos_q[cmi_pkg::AxisPosY] <= min_y_q;
              by_q <= 1'b1;
            end else if (box_en_q && (item_q.value_y > max_y_q)) begin
              pos_q[cmi_pkg::AxisPosY] <= max_y_q;
              by_q <= 1'b1;
            end else begin
              pos_q[cmi_pkg::AxisPosY] <= item_q.value_y;
            end
            if (item_q.clear_motion) begin
              for (int i = 0; i < 3; i++) begin
                vel_q[i] <= '0;
                acc_q[i] <= '0;
              end
            end
          end
          cmi_pkg::OpSetRot: begin
            pos_q[cmi_pkg::AxisRotX] <= item_q.value_x;
            pos_q[cmi_pkg::AxisRotY] <= item_q.value_y;
            if (item_q.clear_motion) begin
              for (int i = 3; i < cmi_pkg::NumAxes; i++) begin
                vel_q[i] <= '0;
                acc_q[i] <= '0;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.add) begin
        pos_q[cmd_i.axis] <= new_p;
      end
      if (cmd_i.wb) begin
        acc_q[cmd_i.axis] <= div_a_res;
        vel_q[cmd_i.axis] <= div_v_res;
      end
      if (cmd_i.clamp && box_en_q) begin
        // A clamped axis reverses its velocity at half speed.
        if ((pos_q[cmi_pkg::AxisPosX] < min_x_q) || (pos_q[cmi_pkg::AxisPosX] > max_x_q)) begin
          pos_q[cmi_pkg::AxisPosX] <= (pos_q[cmi_pkg::AxisPosX] < min_x_q) ? min_x_q : max_x_q;
          vel_q[cmi_pkg::AxisPosX] <= 32'((33'sd0 - 33'(vel_q[cmi_pkg::AxisPosX])) >>> 1);
          bx_q <= 1'b1;
        end
        if ((pos_q[cmi_pkg::AxisPosY] < min_y_q) || (pos_q[cmi_pkg::AxisPosY] > max_y_q)) begin
          pos_q[cmi_pkg::AxisPosY] <= (pos_q[cmi_pkg::AxisPosY] < min_y_q) ? min_y_q : max_y_q;
          vel_q[cmi_pkg::AxisPosY] <= 32'((33'sd0 - 33'(vel_q[cmi_pkg::AxisPosY])) >>> 1);
          by_q <= 1'b1;
        end
      end
    end
  end

  // Item, step products, divisors and the result register need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q  <= in_data_i;
      dd_q    <= in_data_i.step_time * in_data_i.step_time;
      den_a_q <= (in_d << 7) + (in_d << 5) + (in_d << 4) + (in_d << 2);
      den_v_q <= (in_d << 6) + (in_d << 5) + (in_d << 3) + (in_d << 2) + (in_d << 1);
    end
    if (cmd_i.mul) begin
      prod_add_q <= cur_a * $signed({1'b0, dd_q});
      prod_vd_q  <= cur_v * $signed({1'b0, item_q.step_time});
      prod_ad_q  <= cur_a * $signed({1'b0, item_q.step_time});
    end
    if (cmd_i.out_load) begin
      out_q.position_x <= pos_q[cmi_pkg::AxisPosX];
      out_q.position_y <= pos_q[cmi_pkg::AxisPosY];
      out_q.position_z <= pos_q[cmi_pkg::AxisPosZ];
      out_q.rotation_x <= pos_q[cmi_pkg::AxisRotX];
      out_q.rotation_y <= pos_q[cmi_pkg::AxisRotY];
      out_q.bounced_x  <= bx_q;
      out_q.bounced_y  <= by_q;
    end
  end

  assign status_o.is_tick   = (item_q.operation == cmi_pkg::OpTick);
  assign status_o.step_zero = (item_q.step_time == '0);
  assign status_o.div_done  = div_a_done & div_v_done;
  assign out_data_o         = out_q;

endmodule
`default_nettype wire

[hdl/cmi_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmi_ctrl
// Sequencer: walks a tick through the five axes and drives both handshakes.
// ----------------------------------------------------------------------------
module cmi_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire cmi_pkg::status_t  status_i,
  output cmi_pkg::cmd_t          cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StExec   = 3'd1;
  localparam logic [2:0] StMul    = 3'd2;
  localparam logic [2:0] StAdd    = 3'd3;
  localparam logic [2:0] StDiv    = 3'd4;
  localparam logic [2:0] StClamp  = 3'd5;
  localparam logic [2:0] StFinish = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [cmi_pkg::AxisW-1:0] axis_q, axis_d;
  logic                      out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        if (status_i.is_tick && !status_i.step_zero) begin
          axis_d  = cmi_pkg::AxisPosX;
          state_d = StMul;
        end else begin
          cmd_o.simple = 1'b1;
          state_d      = StFinish;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAdd;
      end
      StAdd: begin
        cmd_o.add = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        if (status_i.div_done) begin
          cmd_o.wb = 1'b1;
          if (axis_q == cmi_pkg::AxisRotY) begin
            state_d = StClamp;
          end else begin
            axis_d  = axis_q + 3'd1;
            state_d = StMul;
          end
        end
      end
      StClamp: begin
        cmd_o.clamp = 1'b1;
        state_d     = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[hdl/camera_motion_integrator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// camera_motion_integrator_unit
// Camera position and rotation integrator with damping and box clamp.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o   cmi_pkg::in_item_t
// out       output     out_valid_o/out_stall_i cmi_pkg::out_item_t
// cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// A boost, a set, an unused code or a tick with a zero step passes from idle
// through the execute state to the finish state, which loads the result
// register. A tick runs, for each axis, a multiply, an add and a wait on the
// pair of damping dividers, and a clamp state then clamps the box.
// Reset clears all motion state and the box registers.
// The next transfer is taken as soon as the sequencer is back in idle, even
// while the previous result still waits behind a stalled output.
// ----------------------------------------------------------------------------
module camera_motion_integrator_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire cmi_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output cmi_pkg::out_item_t               out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [cmi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                 cfg_data_i
);

  cmi_pkg::cmd_t    cmd;
  cmi_pkg::status_t status;

  cmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cmi_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
